@@ hdl/hafe_pkg.sv @@
// shared types, constants and helpers of the hex ascii frame encoder
// no dependencies
package hafe_pkg;

    localparam logic [7:0] START_BYTE = 8'hE8;
    localparam logic [7:0] END_BYTE   = 8'hEA;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;

    localparam logic OP_HEADER  = 1'b0;
    localparam logic OP_PAYLOAD = 1'b1;

    localparam int QUEUE_DEPTH = 2;

    // one classified word, as handed from the front to the back
    typedef struct packed {
        logic            err;      // rejected word, one error result
        logic            hdr;      // four frame bytes, else one payload byte
        logic            trailer;  // checksum, end byte and cr lf follow
        logic [7:0]      csum;
        logic [3:0][7:0] bytes;
    } t_job;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10) begin
            c = 8'h30 + {4'd0, nib};
        end else begin
            c = 8'h61 + {4'd0, nib - 4'd10};
        end
        return c;
    endfunction

endpackage

@@ hdl/hafe_front.sv @@
// front part: accepts input words, checks them against the frame state
// and builds one job per word; depends on hafe_pkg
module hafe_front import hafe_pkg::*; #(
    parameter int MAX_MSG_LEN = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic       i_op,
    input  logic [7:0] i_command,
    input  logic [7:0] i_magic,
    input  logic [7:0] i_msg_length,
    input  logic [7:0] i_msg_byte,
    output t_job       o_job
);

    localparam logic [7:0] MAX_LEN = 8'(MAX_MSG_LEN);

    logic       r_open;
    logic [7:0] r_remaining;
    logic [7:0] r_sum;

    logic       n_open;
    logic [7:0] n_remaining;
    logic [7:0] n_sum;

    logic [7:0] hdr_sum;
    logic [7:0] pay_sum;
    logic [7:0] rem_dec;
    t_job       job;

    always_comb begin
        hdr_sum     = START_BYTE + i_msg_length + i_command + i_magic;
        pay_sum     = r_sum + i_msg_byte;
        rem_dec     = r_remaining - 8'd1;
        job         = '0;
        n_open      = r_open;
        n_remaining = r_remaining;
        n_sum       = r_sum;
        if (i_op == OP_HEADER) begin
            job.hdr      = 1'b1;
            job.bytes[0] = START_BYTE;
            job.bytes[1] = i_msg_length;
            job.bytes[2] = i_command;
            job.bytes[3] = i_magic;
            job.csum     = hdr_sum;
            if (i_msg_length > MAX_LEN) begin
                job.err = 1'b1;
            end else if (i_msg_length == 8'd0) begin
                job.trailer = 1'b1;
                n_open      = 1'b0;
                n_remaining = 8'd0;
                n_sum       = 8'd0;
            end else begin
                n_open      = 1'b1;
                n_remaining = i_msg_length;
                n_sum       = hdr_sum;
            end
        end else begin
            job.bytes[0] = i_msg_byte;
            job.csum     = pay_sum;
            if (!r_open) begin
                job.err = 1'b1;
            end else if (rem_dec == 8'd0) begin
                job.trailer = 1'b1;
                n_open      = 1'b0;
                n_remaining = 8'd0;
                n_sum       = 8'd0;
            end else begin
                n_remaining = rem_dec;
                n_sum       = pay_sum;
            end
        end
    end

    assign o_job = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open      <= 1'b0;
            r_remaining <= 8'd0;
            r_sum       <= 8'd0;
        end else if (i_accept) begin
            r_open      <= n_open;
            r_remaining <= n_remaining;
            r_sum       <= n_sum;
        end
    end

endmodule

@@ hdl/hafe_queue.sv @@
// short job queue between front and back
// depends on hafe_pkg
module hafe_queue import hafe_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_job o_head
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_job          r_slot [QUEUE_DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ hdl/hafe_back.sv @@
// back part: walks the head job one character per cycle, while the
// output is not stalled, into the output register; depends on hafe_pkg
module hafe_back import hafe_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_empty,
    input  t_job       i_head,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_ascii_char,
    output logic       o_last_of_run,
    output logic       o_error
);

    // character positions after the data bytes
    localparam logic [3:0] T_SUM_HI = 4'd0;
    localparam logic [3:0] T_SUM_LO = 4'd1;
    localparam logic [3:0] T_END_HI = 4'd2;
    localparam logic [3:0] T_END_LO = 4'd3;
    localparam logic [3:0] T_CR     = 4'd4;
    localparam logic [3:0] T_LF     = 4'd5;

    logic [3:0] r_idx;
    logic       r_valid;
    logic [7:0] r_char;
    logic       r_last;
    logic       r_err;

    logic       advance;
    logic       load;
    logic       last;
    logic [3:0] data_chars;
    logic [3:0] tpos;
    logic [7:0] cur_byte;
    logic [7:0] ch;

    always_comb begin
        data_chars = i_head.hdr ? 4'd8 : 4'd2;
        tpos       = r_idx - data_chars;
        cur_byte   = i_head.bytes[r_idx[2:1]];
        ch         = 8'd0;
        if (i_head.err) begin
            ch = 8'd0;
        end else if (r_idx < data_chars) begin
            ch = hex_char(r_idx[0] ? cur_byte[3:0] : cur_byte[7:4]);
        end else begin
            case (tpos)
                T_SUM_HI: ch = hex_char(i_head.csum[7:4]);
                T_SUM_LO: ch = hex_char(i_head.csum[3:0]);
                T_END_HI: ch = hex_char(END_BYTE[7:4]);
                T_END_LO: ch = hex_char(END_BYTE[3:0]);
                T_CR:     ch = CHAR_CR;
                T_LF:     ch = CHAR_LF;
                default:  ch = 8'd0;
            endcase
        end
        if (i_head.err) begin
            last = 1'b1;
        end else if (i_head.trailer) begin
            last = (tpos == T_LF) && (r_idx >= data_chars);
        end else begin
            last = (r_idx == data_chars - 4'd1);
        end
    end

    assign advance = !r_valid || !i_stall;
    assign load    = advance && !i_empty;
    assign o_pop   = load && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 4'd0;
        end else begin
            if (advance) begin
                r_valid <= !i_empty;
            end
            if (load) begin
                r_idx <= last ? 4'd0 : r_idx + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_char <= ch;
            r_last <= last;
            r_err  <= i_head.err;
        end
    end

    assign o_valid       = r_valid;
    assign o_ascii_char  = r_char;
    assign o_last_of_run = r_last;
    assign o_error       = r_err;

endmodule

@@ hdl/hex_ascii_frame_encoder_unit.sv @@
// top level of the hex ascii frame encoder: front, job queue and back
// depends on hafe_pkg, hafe_front, hafe_queue, hafe_back
//
// Turns header and payload words into a framed stream of lowercase ascii
// hex characters: start byte e8, length, command, magic, payload bytes,
// an 8-bit additive checksum of all earlier bytes and end byte ea, each
// byte as two characters high nibble first, then cr lf. The output gives
// one character per cycle while not stalled, from a single output register,
// and that sets the rate: a header is 8 characters, a payload byte 2,
// the byte closing the frame 8, a zero-length header 14, a rejected word 1.
// Input words are taken every cycle while the two-entry job queue between
// the front and the back has room. A job stays in the queue until its
// last character is loaded, so up to two words wait there, the one being
// sent among them, beside the character held in the output register.
// A header longer than
// MAX_MSG_LEN, or a payload byte with no frame open, gives a single
// result with error and last_of_run set and leaves the frame state as it
// was. A header that arrives while a frame is open drops that frame with
// no trailer. last_of_run marks the final character of each input word.
module hex_ascii_frame_encoder_unit import hafe_pkg::*; #(
    parameter int MAX_MSG_LEN = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input word channel
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_op,
    input  logic [7:0] i_command,
    input  logic [7:0] i_magic,
    input  logic [7:0] i_msg_length,
    input  logic [7:0] i_msg_byte,
    // character channel
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_ascii_char,
    output logic       o_last_of_run,
    output logic       o_error
);

    logic accept;
    logic q_full;
    logic q_empty;
    logic q_pop;
    t_job front_job;
    t_job head_job;

    // stall only on a full queue, never on the output side directly
    assign o_stall = q_full;
    assign accept  = i_valid && !q_full;

    hafe_front #(
        .MAX_MSG_LEN (MAX_MSG_LEN)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_op         (i_op),
        .i_command    (i_command),
        .i_magic      (i_magic),
        .i_msg_length (i_msg_length),
        .i_msg_byte   (i_msg_byte),
        .o_job        (front_job)
    );

    // every accepted word, rejected ones too, leaves one job
    hafe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_job   (front_job),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head_job)
    );

    hafe_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (q_empty),
        .i_head        (head_job),
        .o_pop         (q_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_ascii_char  (o_ascii_char),
        .o_last_of_run (o_last_of_run),
        .o_error       (o_error)
    );

endmodule

@@ hdl/hafe_checker.sv @@
// port-level checks of the hex ascii frame encoder, bound to the top level
// depends on hex_ascii_frame_encoder_unit
module hafe_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_ascii_char,
    input logic       o_last_of_run,
    input logic       o_error
);

    // an error result stands alone
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error |-> o_last_of_run)
        else $error("error result without last_of_run");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error |-> o_ascii_char == 8'h00)
        else $error("error result with non-zero character");

    // lf only ever closes a frame
    a_lf_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_error && o_ascii_char == 8'h0A |-> o_last_of_run)
        else $error("lf not marked last");

    // cr is always followed by lf
    a_cr_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_error && o_ascii_char == 8'h0D
        |=> o_valid && o_ascii_char == 8'h0A)
        else $error("cr not followed by lf");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_ascii_char)
        && $stable(o_last_of_run) && $stable(o_error))
        else $error("stalled word changed");

endmodule

bind hex_ascii_frame_encoder_unit hafe_checker u_hafe_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_ascii_char  (o_ascii_char),
    .o_last_of_run (o_last_of_run),
    .o_error       (o_error)
);
